// File: src/pic_pkg.sv
package pic_pkg;

	// pipeline control shared by the iterative stage chains
	typedef struct packed {
		logic adv;
		logic vld;
	} ctl_t;

	// register map
	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_WORLD_WIDTH  = 1'd0;
	localparam logic [0:0] REG_WORLD_HEIGHT = 1'd1;

endpackage

// File: src/pic_wmul.sv
module pic_wmul #(
	parameter int AW = 49,
	parameter int BW = 49
) (
	input  logic              clk,
	input  logic              adv,
	input  logic [AW-1:0]     a,
	input  logic [BW-1:0]     b,
	output logic [AW+BW-1:0]  p
);

	localparam int AL = (AW + 1) / 2;
	localparam int AH = AW - AL;
	localparam int BL = (BW + 1) / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH+BL-1:0] hl_s1;
	logic [AH+BH-1:0] hh_s1;
	logic [PW-1:0]    p_s2;

	// partial products of the operand halves
	always_ff @(posedge clk) begin
		if (adv) begin
			ll_s1 <= a[AL-1:0] * b[BL-1:0];
			lh_s1 <= a[AL-1:0] * b[BW-1:BL];
			hl_s1 <= a[AW-1:AL] * b[BL-1:0];
			hh_s1 <= a[AW-1:AL] * b[BW-1:BL];
		end
	end

	// weighted sum of the partial products
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2 <= PW'(ll_s1) + (PW'(lh_s1) << BL) + (PW'(hl_s1) << AL)
				+ (PW'(hh_s1) << (AL + BL));
		end
	end

	assign p = p_s2;

endmodule

// File: src/pic_sqrt.sv
module pic_sqrt #(
	parameter int SW   = 100,
	parameter int TAGW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pic_pkg::ctl_t      ctl,
	input  logic [SW-1:0]      rad,
	input  logic [TAGW-1:0]    tag_in,
	output logic [SW/2-1:0]    root,
	output logic [TAGW-1:0]    tag_out,
	output logic               vld
);

	localparam int RW  = SW / 2;
	localparam int RMW = RW + 3;

	logic [RMW-1:0]  rem_s  [RW+1];
	logic [RW-1:0]   root_s [RW+1];
	logic [SW-1:0]   rad_s  [RW+1];
	logic [TAGW-1:0] tag_s  [RW+1];
	logic            vld_s  [RW+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;
	assign tag_s[0]  = tag_in;
	assign vld_s[0]  = ctl.vld;

	// one result bit per stage, digit by digit
	for (genvar i = 0; i < RW; i++) begin : g_step
		logic [RMW-1:0] cur;
		logic [RMW-1:0] trial;
		logic           ge;

		assign cur   = {rem_s[i][RMW-3:0], rad_s[i][SW-1 -: 2]};
		assign trial = RMW'({root_s[i], 2'b01});
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (ctl.adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				rem_s[i+1]  <= ge ? cur - trial : cur;
				root_s[i+1] <= {root_s[i][RW-2:0], ge};
				rad_s[i+1]  <= {rad_s[i][SW-3:0], 2'b00};
				tag_s[i+1]  <= tag_s[i];
			end
		end
	end

	assign root    = root_s[RW];
	assign tag_out = tag_s[RW];
	assign vld     = vld_s[RW];

endmodule

// File: src/pic_div.sv
module pic_div #(
	parameter int NUMW = 59,
	parameter int KW   = 46,
	parameter int TAGW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pic_pkg::ctl_t      ctl,
	input  logic [NUMW-1:0]    num,
	input  logic [KW-1:0]      den,
	input  logic [TAGW-1:0]    tag_in,
	output logic [NUMW-1:0]    quo,
	output logic [TAGW-1:0]    tag_out,
	output logic               vld
);

	logic [KW-1:0]   r_s   [NUMW+1];
	logic [NUMW-1:0] q_s   [NUMW+1];
	logic [NUMW-1:0] n_s   [NUMW+1];
	logic [KW-1:0]   d_s   [NUMW+1];
	logic [TAGW-1:0] tag_s [NUMW+1];
	logic            vld_s [NUMW+1];

	assign r_s[0]   = '0;
	assign q_s[0]   = '0;
	assign n_s[0]   = num;
	assign d_s[0]   = den;
	assign tag_s[0] = tag_in;
	assign vld_s[0] = ctl.vld;

	// restoring division, one quotient bit per stage
	for (genvar i = 0; i < NUMW; i++) begin : g_step
		logic [KW:0] cur;
		logic [KW:0] diff;
		logic        ge;

		assign cur  = {r_s[i], n_s[i][NUMW-1]};
		assign diff = cur - {1'b0, d_s[i]};
		assign ge   = cur >= {1'b0, d_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (ctl.adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				r_s[i+1]   <= ge ? diff[KW-1:0] : cur[KW-1:0];
				q_s[i+1]   <= {q_s[i][NUMW-2:0], ge};
				n_s[i+1]   <= {n_s[i][NUMW-2:0], 1'b0};
				d_s[i+1]   <= d_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign quo     = q_s[NUMW];
	assign tag_out = tag_s[NUMW];
	assign vld     = vld_s[NUMW];

endmodule

// File: src/projectile_intercept_point_top.sv
// Lead point unit: aim point for a constant-speed projectile against a target
// moving in a straight line, clamped to the world rectangle.
// Query channel: query_valid / query_stall with the firing point, projectile
// speed and target position and velocity. Result channel: result_valid /
// result_stall with aim_x, aim_y and lead_valid (0 when the target is
// stationary or not slower than the projectile; the target position is then
// passed through unclamped).
// World bounds are written over the APB port at 0x0 (width) and 0x4 (height)
// and should only change while no transaction is in flight.
// Throughput: one transaction per cycle while result_stall does not hold the
// pipeline. The path runs through the square-root chain (2*COORD_BITS+3
// stages) and the divider chain (2*COORD_BITS+FRAC_BITS+4 stages), plus
// the multiplier, clamp and other registered stages.
// When the result register is full and result_stall is high the whole
// pipeline holds and query_stall rises; nothing is dropped or repeated.
// Reset clears all valid bits and the world bounds.
module projectile_intercept_point_top #(
	parameter int COORD_BITS = 24,
	parameter int FRAC_BITS  = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pic_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              query_valid,
	output logic                              query_stall,
	input  logic signed [COORD_BITS-1:0]      fire_x,
	input  logic signed [COORD_BITS-1:0]      fire_y,
	input  logic [COORD_BITS-2:0]             projectile_speed,
	input  logic signed [COORD_BITS-1:0]      target_x,
	input  logic signed [COORD_BITS-1:0]      target_y,
	input  logic signed [COORD_BITS-1:0]      target_vel_x,
	input  logic signed [COORD_BITS-1:0]      target_vel_y,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [COORD_BITS-1:0]      aim_x,
	output logic signed [COORD_BITS-1:0]      aim_y,
	output logic                              lead_valid
);

	localparam int CW   = COORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int DW   = CW + 1;
	localparam int VW   = CW;
	localparam int PW   = CW - 1;
	localparam int P1W  = DW + VW;
	localparam int DVW  = P1W + 1;
	localparam int DSW  = 2 * DW;
	localparam int D2W  = DSW + 1;
	localparam int VSW  = 2 * VW;
	localparam int VT2W = VSW + 1;
	localparam int KW   = 2 * PW;
	localparam int SW   = 2 * DVW + 2;
	localparam int RW   = SW / 2;
	localparam int NW   = RW + 1;
	localparam int QW   = NW + F;
	localparam int TW   = CW + F + 3;
	localparam int MW   = TW + VW;
	localparam int OW   = CW + 2;
	localparam int AW   = CW + 4;

	localparam logic [QW-1:0]   T_LIM  = QW'(1) << (TW - 1);
	localparam logic [MW-1:0]   HALF   = MW'(1) << (F - 1);
	localparam logic [MW-F-1:0] OFF_CAP = (MW - F)'(1) << (CW + 1);

	typedef struct packed {
		logic signed [CW-1:0] tx;
		logic signed [CW-1:0] ty;
		logic [VW-1:0]        avx;
		logic [VW-1:0]        avy;
		logic                 svx;
		logic                 svy;
		logic                 special;
	} geo_t;

	typedef struct packed {
		geo_t           geo;
		logic [DVW-1:0] dv;
		logic           dvneg;
		logic [KW-1:0]  k;
	} root_tag_t;

	localparam int GEO_W  = $bits(geo_t);
	localparam int RTAG_W = $bits(root_tag_t);

	// offset per axis: round, saturate, apply sign, add to position
	function automatic logic signed [AW-1:0] lead_sum(logic signed [CW-1:0] pos,
			logic [MW-1:0] prod, logic neg);
		logic [MW-1:0]         r;
		logic [MW-F-1:0]       m;
		logic [OW-1:0]         o;
		logic signed [AW-1:0]  so;
		r  = prod + HALF;
		m  = r[MW-1:F];
		o  = (m > OFF_CAP) ? OFF_CAP[OW-1:0] : m[OW-1:0];
		so = neg ? -$signed(AW'(o)) : $signed(AW'(o));
		return AW'(pos) + so;
	endfunction

	// clamp into [0, lim]
	function automatic logic [CW-1:0] clamp_axis(logic signed [AW-1:0] a,
			logic [CW-2:0] lim);
		logic signed [AW-1:0] c;
		c = (a > $signed(AW'(lim))) ? $signed(AW'(lim)) : a;
		if (c < 0) begin
			c = '0;
		end
		return c[CW-1:0];
	endfunction

	logic          adv;
	pic_pkg::ctl_t sq_ctl;
	pic_pkg::ctl_t dv_ctl;

	// config registers
	logic [CW-2:0] world_w_q;
	logic [CW-2:0] world_h_q;

	// apb write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_w_q <= '0;
			world_h_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2:2])
				pic_pkg::REG_WORLD_WIDTH:  world_w_q <= pwdata[CW-2:0];
				pic_pkg::REG_WORLD_HEIGHT: world_h_q <= pwdata[CW-2:0];
				default: ;
			endcase
		end
	end

	// apb read
	always_comb begin
		case (paddr[2:2])
			pic_pkg::REG_WORLD_WIDTH:  prdata = 32'(world_w_q);
			pic_pkg::REG_WORLD_HEIGHT: prdata = 32'(world_h_q);
			default:                   prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// whole pipeline holds while the result register is blocked
	assign adv         = !(result_valid && result_stall);
	assign query_stall = !adv;

	// stage 1: offsets and magnitudes
	logic signed [CW:0] dx_w;
	logic signed [CW:0] dy_w;
	logic [DW-1:0]      adx_w;
	logic [DW-1:0]      ady_w;
	logic [VW-1:0]      avx_w;
	logic [VW-1:0]      avy_w;

	assign dx_w  = (CW + 1)'(target_x) - (CW + 1)'(fire_x);
	assign dy_w  = (CW + 1)'(target_y) - (CW + 1)'(fire_y);
	assign adx_w = dx_w[CW] ? -dx_w : dx_w;
	assign ady_w = dy_w[CW] ? -dy_w : dy_w;
	assign avx_w = target_vel_x[CW-1] ? -target_vel_x : target_vel_x;
	assign avy_w = target_vel_y[CW-1] ? -target_vel_y : target_vel_y;

	logic                 vld_s1;
	logic [DW-1:0]        adx_s1;
	logic [DW-1:0]        ady_s1;
	logic [VW-1:0]        avx_s1;
	logic [VW-1:0]        avy_s1;
	logic                 sdx_s1;
	logic                 sdy_s1;
	logic                 svx_s1;
	logic                 svy_s1;
	logic [PW-1:0]        ap_s1;
	logic signed [CW-1:0] tx_s1;
	logic signed [CW-1:0] ty_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= query_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			adx_s1 <= adx_w;
			ady_s1 <= ady_w;
			avx_s1 <= avx_w;
			avy_s1 <= avy_w;
			sdx_s1 <= dx_w[CW];
			sdy_s1 <= dy_w[CW];
			svx_s1 <= target_vel_x[CW-1];
			svy_s1 <= target_vel_y[CW-1];
			ap_s1  <= projectile_speed;
			tx_s1  <= target_x;
			ty_s1  <= target_y;
		end
	end

	// stage 2: narrow products
	logic                 vld_s2;
	logic [P1W-1:0]       pxv_s2;
	logic [P1W-1:0]       pyv_s2;
	logic                 nx_s2;
	logic                 ny_s2;
	logic [DSW-1:0]       dxx_s2;
	logic [DSW-1:0]       dyy_s2;
	logic [VSW-1:0]       vxx_s2;
	logic [VSW-1:0]       vyy_s2;
	logic [KW-1:0]        pp_s2;
	geo_t                 geo_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pxv_s2          <= adx_s1 * avx_s1;
			pyv_s2          <= ady_s1 * avy_s1;
			nx_s2           <= sdx_s1 ^ svx_s1;
			ny_s2           <= sdy_s1 ^ svy_s1;
			dxx_s2          <= adx_s1 * adx_s1;
			dyy_s2          <= ady_s1 * ady_s1;
			vxx_s2          <= avx_s1 * avx_s1;
			vyy_s2          <= avy_s1 * avy_s1;
			pp_s2           <= ap_s1 * ap_s1;
			geo_s2.tx       <= tx_s1;
			geo_s2.ty       <= ty_s1;
			geo_s2.avx      <= avx_s1;
			geo_s2.avy      <= avy_s1;
			geo_s2.svx      <= svx_s1;
			geo_s2.svy      <= svy_s1;
			geo_s2.special  <= 1'b0;
		end
	end

	// stage 3: dot product, squared distance, speed margin
	logic signed [DVW:0] tx_term_w;
	logic signed [DVW:0] ty_term_w;
	logic signed [DVW:0] dvs_w;
	logic signed [DVW:0] ndv_w;
	logic [VT2W-1:0]     vt2_w;

	assign tx_term_w = nx_s2 ? -$signed((DVW + 1)'(pxv_s2)) : $signed((DVW + 1)'(pxv_s2));
	assign ty_term_w = ny_s2 ? -$signed((DVW + 1)'(pyv_s2)) : $signed((DVW + 1)'(pyv_s2));
	assign dvs_w     = tx_term_w + ty_term_w;
	assign ndv_w     = -dvs_w;
	assign vt2_w     = VT2W'(vxx_s2) + VT2W'(vyy_s2);

	logic           vld_s3;
	logic [DVW-1:0] dv_s3;
	logic [D2W-1:0] d2_s3;
	root_tag_t      tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s3               <= dvs_w[DVW] ? ndv_w[DVW-1:0] : dvs_w[DVW-1:0];
			d2_s3               <= D2W'(dxx_s2) + D2W'(dyy_s2);
			tag_s3.geo.tx       <= geo_s2.tx;
			tag_s3.geo.ty       <= geo_s2.ty;
			tag_s3.geo.avx      <= geo_s2.avx;
			tag_s3.geo.avy      <= geo_s2.avy;
			tag_s3.geo.svx      <= geo_s2.svx;
			tag_s3.geo.svy      <= geo_s2.svy;
			tag_s3.geo.special  <= (vt2_w == '0) || (vt2_w >= VT2W'(pp_s2));
			tag_s3.dv           <= dvs_w[DVW] ? ndv_w[DVW-1:0] : dvs_w[DVW-1:0];
			tag_s3.dvneg        <= dvs_w[DVW];
			tag_s3.k            <= pp_s2 - vt2_w[KW-1:0];
		end
	end

	// stages 4 and 5: wide products split into partial products
	logic [2*DVW-1:0]  dvsq_w;
	logic [D2W+KW-1:0] d2k_w;

	pic_wmul #(.AW(DVW), .BW(DVW)) u_mul_dv (
		.clk (clk),
		.adv (adv),
		.a   (dv_s3),
		.b   (dv_s3),
		.p   (dvsq_w)
	);

	pic_wmul #(.AW(D2W), .BW(KW)) u_mul_d2k (
		.clk (clk),
		.adv (adv),
		.a   (d2_s3),
		.b   (tag_s3.k),
		.p   (d2k_w)
	);

	logic      vld_s4;
	logic      vld_s5;
	root_tag_t tag_s4;
	root_tag_t tag_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	// stage 6: discriminant
	logic          vld_s6;
	logic [SW-1:0] disc_s6;
	root_tag_t     tag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			disc_s6 <= SW'(dvsq_w) + SW'(d2k_w);
			tag_s6  <= tag_s5;
		end
	end

	// square root chain
	logic [RW-1:0]     root_w;
	logic [RTAG_W-1:0] rtag_w;
	logic              rvld_w;
	root_tag_t         rtag;

	assign sq_ctl = '{adv: adv, vld: vld_s6};

	pic_sqrt #(.SW(SW), .TAGW(RTAG_W)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (sq_ctl),
		.rad     (disc_s6),
		.tag_in  (tag_s6),
		.root    (root_w),
		.tag_out (rtag_w),
		.vld     (rvld_w)
	);

	assign rtag = root_tag_t'(rtag_w);

	// stage 7: numerator
	logic          vld_s7;
	logic [NW-1:0] num_s7;
	logic [KW-1:0] k_s7;
	geo_t          geo_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= rvld_w;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s7 <= rtag.dvneg ? NW'(root_w) - NW'(rtag.dv) : NW'(root_w) + NW'(rtag.dv);
			k_s7   <= rtag.k;
			geo_s7 <= rtag.geo;
		end
	end

	// divider chain
	logic [QW-1:0]    quo_w;
	logic [GEO_W-1:0] dtag_w;
	logic             dvld_w;
	geo_t             dgeo;

	assign dv_ctl = '{adv: adv, vld: vld_s7};

	pic_div #(.NUMW(QW), .KW(KW), .TAGW(GEO_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (dv_ctl),
		.num     ({num_s7, F'(0)}),
		.den     (k_s7),
		.tag_in  (geo_s7),
		.quo     (quo_w),
		.tag_out (dtag_w),
		.vld     (dvld_w)
	);

	assign dgeo = geo_t'(dtag_w);

	// stage e1: limit intercept time (larger values saturate the offset anyway)
	logic          vld_e1;
	logic [TW-1:0] t_e1;
	geo_t          geo_e1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_e1 <= 1'b0;
		end else if (adv) begin
			vld_e1 <= dvld_w;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_e1   <= (quo_w > T_LIM) ? T_LIM[TW-1:0] : quo_w[TW-1:0];
			geo_e1 <= dgeo;
		end
	end

	// stage e2: offset products
	logic          vld_e2;
	logic [MW-1:0] mx_e2;
	logic [MW-1:0] my_e2;
	geo_t          geo_e2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_e2 <= 1'b0;
		end else if (adv) begin
			vld_e2 <= vld_e1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_e2  <= t_e1 * geo_e1.avx;
			my_e2  <= t_e1 * geo_e1.avy;
			geo_e2 <= geo_e1;
		end
	end

	// stage e3: rounded offsets added to the target position
	logic                 vld_e3;
	logic signed [AW-1:0] ax_e3;
	logic signed [AW-1:0] ay_e3;
	geo_t                 geo_e3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_e3 <= 1'b0;
		end else if (adv) begin
			vld_e3 <= vld_e2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_e3  <= lead_sum(geo_e2.tx, mx_e2, geo_e2.svx);
			ay_e3  <= lead_sum(geo_e2.ty, my_e2, geo_e2.svy);
			geo_e3 <= geo_e2;
		end
	end

	// result register: clamp or pass the target through
	logic                 out_vld_q;
	logic signed [CW-1:0] aim_x_q;
	logic signed [CW-1:0] aim_y_q;
	logic                 lead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_e3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (geo_e3.special) begin
				aim_x_q <= geo_e3.tx;
				aim_y_q <= geo_e3.ty;
				lead_q  <= 1'b0;
			end else begin
				aim_x_q <= clamp_axis(ax_e3, world_w_q);
				aim_y_q <= clamp_axis(ay_e3, world_h_q);
				lead_q  <= 1'b1;
			end
		end
	end

	assign result_valid = out_vld_q;
	assign aim_x        = aim_x_q;
	assign aim_y        = aim_y_q;
	assign lead_valid   = lead_q;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

typedef bit [191:0] wide_t;

typedef struct {
	logic signed [23:0] fx;
	logic signed [23:0] fy;
	logic [22:0]        speed;
	logic signed [23:0] tx;
	logic signed [23:0] ty;
	logic signed [23:0] vx;
	logic signed [23:0] vy;
} query_t;

typedef struct {
	logic signed [23:0] ax;
	logic signed [23:0] ay;
	logic               lv;
} aim_t;

class aim_scoreboard;
	longint world_w;
	longint world_h;
	aim_t   pending_aims[$];
	int     errors;

	function new();
		world_w = 0;
		world_h = 0;
		errors  = 0;
	endfunction

	// floor integer square root, two bits per step
	function wide_t isqrt(wide_t a);
		wide_t root, rem, trial;
		root = 0;
		rem  = 0;
		for (int i = 190; i >= 0; i -= 2) begin
			rem   = (rem << 2) | ((a >> i) & 3);
			trial = (root << 2) | 1;
			root  = root << 1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = root | 1;
			end
		end
		return root;
	endfunction

	// offset along one axis, saturated, then clamped to [0, bound]
	function logic [23:0] lead_coord(longint tpos, longint vel, wide_t t, longint bound);
		wide_t  m;
		longint mag, pt;
		m = (t * wide_t'(vel < 0 ? -vel : vel) + 128) >> 8;
		if (m > (wide_t'(1) << 25))
			m = wide_t'(1) << 25;
		mag = longint'(m[63:0]);
		pt  = tpos + (vel < 0 ? -mag : mag);
		if (pt > bound)
			pt = bound;
		if (pt < 0)
			pt = 0;
		return pt[23:0];
	endfunction

	function aim_t predict_aim(query_t q);
		aim_t   r;
		longint fx, fy, tx, ty, vx, vy, p, vt2, vp2, dx, dy, dv, dvm, d2, k;
		wide_t  disc, s, num, t;
		fx  = q.fx;
		fy  = q.fy;
		tx  = q.tx;
		ty  = q.ty;
		vx  = q.vx;
		vy  = q.vy;
		p   = longint'(q.speed);
		vt2 = vx * vx + vy * vy;
		vp2 = p * p;
		// stationary or not slower than the projectile: pass through
		if (vt2 == 0 || vt2 >= vp2) begin
			r.ax = q.tx;
			r.ay = q.ty;
			r.lv = 1'b0;
			return r;
		end
		dx   = tx - fx;
		dy   = ty - fy;
		dv   = dx * vx + dy * vy;
		dvm  = dv < 0 ? -dv : dv;
		d2   = dx * dx + dy * dy;
		k    = vp2 - vt2;
		disc = wide_t'(dvm) * wide_t'(dvm) + wide_t'(d2) * wide_t'(k);
		s    = isqrt(disc);
		num  = dv < 0 ? s - wide_t'(dvm) : s + wide_t'(dvm);
		t    = (num << 8) / wide_t'(k);
		r.ax = lead_coord(tx, vx, t, world_w);
		r.ay = lead_coord(ty, vy, t, world_h);
		r.lv = 1'b1;
		return r;
	endfunction

	function void note_query(query_t q);
		pending_aims = {pending_aims, predict_aim(q)};
	endfunction

	function void check_aim(logic signed [23:0] ax, logic signed [23:0] ay, logic lv);
		aim_t e;
		if (pending_aims.size() == 0) begin
			$display("%0t: unexpected result aim_x=%0d aim_y=%0d lead_valid=%0b",
				$time, ax, ay, lv);
			errors++;
			return;
		end
		e = pending_aims.pop_front();
		if (ax !== e.ax) begin
			$display("%0t: aim_x expected %0d actual %0d", $time, e.ax, ax);
			errors++;
		end
		if (ay !== e.ay) begin
			$display("%0t: aim_y expected %0d actual %0d", $time, e.ay, ay);
			errors++;
		end
		if (lv !== e.lv) begin
			$display("%0t: lead_valid expected %0b actual %0b", $time, e.lv, lv);
			errors++;
		end
	endfunction
endclass

module testbench;

	localparam int LATENCY = 122;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [pic_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic query_valid, query_stall;
	logic signed [23:0] fire_x, fire_y, target_x, target_y, target_vel_x, target_vel_y;
	logic [22:0] projectile_speed;
	logic result_valid, result_stall;
	logic signed [23:0] aim_x, aim_y;
	logic lead_valid;

	aim_scoreboard sb;
	bit quiet;
	bit hold_req;
	int cycles;

	projectile_intercept_point_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.query_valid(query_valid), .query_stall(query_stall),
		.fire_x(fire_x), .fire_y(fire_y), .projectile_speed(projectile_speed),
		.target_x(target_x), .target_y(target_y),
		.target_vel_x(target_vel_x), .target_vel_y(target_vel_y),
		.result_valid(result_valid), .result_stall(result_stall),
		.aim_x(aim_x), .aim_y(aim_y), .lead_valid(lead_valid)
	);

	// clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_aim(aim_x, aim_y, lead_valid);
	end

	// receiver stall bursts and the long hold-off
	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (400) @(posedge clk);
				result_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic apb_write(logic [0:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= pic_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == pic_pkg::REG_WORLD_WIDTH)
			sb.world_w = longint'(value[22:0]);
		else
			sb.world_h = longint'(value[22:0]);
	endtask

	task automatic set_world(logic [31:0] w, logic [31:0] h);
		apb_write(pic_pkg::REG_WORLD_WIDTH, w);
		apb_write(pic_pkg::REG_WORLD_HEIGHT, h);
	endtask

	// wait until every expected result has come, then let the pipe settle
	task automatic drain();
		query_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_aims.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic send_query(query_t q);
		fire_x           <= q.fx;
		fire_y           <= q.fy;
		projectile_speed <= q.speed;
		target_x         <= q.tx;
		target_y         <= q.ty;
		target_vel_x     <= q.vx;
		target_vel_y     <= q.vy;
		query_valid      <= 1'b1;
		@(posedge clk);
		while (query_stall)
			@(posedge clk);
		sb.note_query(q);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			query_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	function automatic query_t mk(longint fx, longint fy, longint p, longint tx,
		longint ty, longint vx, longint vy);
		query_t q;
		q.fx    = fx[23:0];
		q.fy    = fy[23:0];
		q.speed = p[22:0];
		q.tx    = tx[23:0];
		q.ty    = ty[23:0];
		q.vx    = vx[23:0];
		q.vy    = vy[23:0];
		return q;
	endfunction

	// mostly solvable queries, some noise and degenerate targets
	function automatic query_t random_query(int span);
		query_t q;
		int     sel, pbits;
		longint p, vlim;
		sel = $urandom_range(0, 99);
		q.fx = $urandom();
		q.fy = $urandom();
		q.tx = $urandom();
		q.ty = $urandom();
		q.vx = $urandom();
		q.vy = $urandom();
		q.speed = $urandom();
		if (sel < 70) begin
			pbits = $urandom_range(2, 23);
			p = $urandom_range(2, (1 << pbits) - 1);
			vlim = p / 2;
			q.speed = p[22:0];
			q.vx = 24'(longint'($urandom_range(0, 2 * vlim)) - vlim);
			q.vy = 24'(longint'($urandom_range(0, 2 * vlim)) - vlim);
			if (span < 23) begin
				q.fx = 24'($urandom_range(0, 1 << span));
				q.fy = 24'($urandom_range(0, 1 << span));
				q.tx = 24'($urandom_range(0, 1 << span));
				q.ty = 24'($urandom_range(0, 1 << span));
			end
		end else if (sel < 80) begin
			q.vx = '0;
			q.vy = '0;
		end else if (sel < 90) begin
			q.speed = 23'($urandom_range(0, 8));
		end
		return q;
	endfunction

	task automatic run_random(int n, int span);
		for (int i = 0; i < n; i++)
			send_query(random_query(span));
	endtask

	initial begin
		sb = new();
		cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		query_valid = 1'b0;
		fire_x = '0;
		fire_y = '0;
		projectile_speed = '0;
		target_x = '0;
		target_y = '0;
		target_vel_x = '0;
		target_vel_y = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and special cases at the widest world
		set_world(32'hFFFF_FFFF, 32'h007F_FFFF);
		send_query(mk(0, 0, 0, 100, 200, 0, 0));
		send_query(mk(0, 0, 8388607, -8388608, 8388607, 0, 0));
		send_query(mk(0, 0, 0, 5, -5, 1, 0));
		send_query(mk(0, 0, 5, 10, 10, 4, 3));
		send_query(mk(0, 0, 5, 10, 10, -5, 0));
		send_query(mk(0, 0, 1000, 5000, 7000, 300, -200));
		send_query(mk(-8388608, -8388608, 8388607, 8388607, 8388607, -8388608, 0));
		send_query(mk(8388607, 8388607, 8388607, -8388608, -8388608, 8388607, 8388607));
		send_query(mk(-8388608, 8388607, 8388607, 8388607, -8388608, 1, -1));
		send_query(mk(-8388608, -8388608, 6, 8388607, 8388607, 4, 4));
		send_query(mk(8388607, 8388607, 6, -8388608, -8388608, -4, -4));
		send_query(mk(0, 0, 8388607, 1000, 1000, -8388607, 0));
		send_query(mk(100, 100, 8388607, 100, 100, 1000, 1000));
		send_query(mk(0, 0, 256, 256, 256, 1, 128));
		send_query(mk(-1, -1, 3, -1, -1, 1, 1));
		send_query(mk(0, 0, 4000000, 2000000, -3000000, -1000000, 2000000));
		drain();

		// random bounds, with a long receiver hold and a sender pause
		set_world($urandom(), $urandom());
		run_random(100, 23);
		hold_req = 1'b1;
		run_random(100, 23);
		query_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_aims.size() != 0)
			@(posedge clk);
		run_random(100, 23);
		drain();

		// zero-size world
		set_world(0, 0);
		run_random(100, 23);
		drain();

		// modest world, positions mostly limited to [0, 2^20], no idling at the end
		set_world($urandom_range(1 << 18, 1 << 21), $urandom_range(1 << 18, 1 << 21));
		run_random(100, 20);
		quiet = 1'b1;
		run_random(100, 20);
		drain();

		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
